>>> design/ruh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ruh_pkg
// Shared constants, codes and types of the register usage histogram core.
// ----------------------------------------------------------------------------
package ruh_pkg;

	localparam int REG_COUNT_MAX = 256;
	localparam int HIST_LEN_MAX  = 4096;
	localparam int REG_W   = $clog2(REG_COUNT_MAX);
	localparam int RCNT_W  = $clog2(REG_COUNT_MAX) + 1;
	localparam int BIN_W   = $clog2(HIST_LEN_MAX);
	localparam int LEN_W   = $clog2(HIST_LEN_MAX) + 1;
	localparam int STAMP_W = 32;
	localparam int CNT_W   = 32;

	localparam logic [REG_W-1:0] SKIP_REG_A = REG_W'(0);
	localparam logic [REG_W-1:0] SKIP_REG_B = REG_W'(28);

	localparam logic [1:0] FN_READ     = 2'd0;
	localparam logic [1:0] FN_RD_STAMP = 2'd1;
	localparam logic [1:0] FN_WRITE    = 2'd2;
	localparam logic [1:0] FN_READOUT  = 2'd3;

	localparam logic [2:0] TBL_RI     = 3'd0;
	localparam logic [2:0] TBL_LIFE   = 3'd1;
	localparam logic [2:0] TBL_DU     = 3'd2;
	localparam logic [2:0] TBL_READS  = 3'd3;
	localparam logic [2:0] TBL_WRITES = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_DIST   = 2'd1;
	localparam logic [1:0] ST_BADREG = 2'd2;
	localparam logic [1:0] ST_BADBIN = 2'd3;

	localparam logic [1:0] CFG_USE_LEN   = 2'd0;
	localparam logic [1:0] CFG_LIFE_LEN  = 2'd1;
	localparam logic [1:0] CFG_REG_COUNT = 2'd2;

	typedef struct packed {
		logic latch;
		logic rd;
		logic calc;
		logic hrd;
		logic wb;
		logic clr;
	} ruh_cmd_t;

	typedef struct packed {
		logic clr_last;
	} ruh_stat_t;

endpackage

>>> design/ruh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ruh_ctrl
// Sequencer: memory clear after reset, then read, compute, histogram read
// and write-back for each item.
// ----------------------------------------------------------------------------
module ruh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ruh_pkg::ruh_stat_t stat,
	output ruh_pkg::ruh_cmd_t  cmd,
	output logic              busy
);
	import ruh_pkg::*;

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_RD   = 6'b000100,
		S_CALC = 6'b001000,
		S_HRD  = 6'b010000,
		S_WB   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR:  if (stat.clr_last) state_d = S_IDLE;
			S_IDLE: if (start) state_d = S_RD;
			S_RD:   state_d = S_CALC;
			S_CALC: state_d = S_HRD;
			S_HRD:  state_d = S_WB;
			S_WB:   state_d = S_IDLE;
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else state_q <= state_d;
	end

	always_comb begin
		cmd.latch = (state_q == S_IDLE) && start;
		cmd.rd    = (state_q == S_RD);
		cmd.calc  = (state_q == S_CALC);
		cmd.hrd   = (state_q == S_HRD);
		cmd.wb    = (state_q == S_WB);
		cmd.clr   = (state_q == S_CLR);
		busy      = (state_q != S_IDLE);
	end

endmodule

>>> design/ruh_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ruh_dp
// Datapath: config registers, per-register tables, histograms and result.
// ----------------------------------------------------------------------------
module ruh_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ruh_pkg::ruh_cmd_t           cmd,
	output ruh_pkg::ruh_stat_t          stat,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [ruh_pkg::LEN_W-1:0]   cfg_data,
	input  logic [1:0]                  func,
	input  logic [ruh_pkg::STAMP_W-1:0] instr_num,
	input  logic                        stats_enable,
	input  logic [ruh_pkg::REG_W-1:0]   reg_index,
	input  logic [2:0]                  table_select,
	input  logic [ruh_pkg::BIN_W-1:0]   bin_index,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [ruh_pkg::BIN_W-1:0]   distance,
	output logic [ruh_pkg::CNT_W-1:0]   count
);
	import ruh_pkg::*;

	function automatic logic [BIN_W-1:0] bin_of(input logic [STAMP_W-1:0] now,
		input logic [STAMP_W-1:0] prev, input logic [LEN_W-1:0] len);
		logic [STAMP_W-1:0] d;
		logic [LEN_W-1:0]   lm1;
		d   = now - prev;
		lm1 = len - LEN_W'(1);
		if (d >= STAMP_W'(len)) return lm1[BIN_W-1:0];
		else return d[BIN_W-1:0];
	endfunction

	// configuration
	logic [LEN_W-1:0]  use_len_q, life_len_q;
	logic [RCNT_W-1:0] reg_count_q;
	logic [LEN_W-1:0]  ulen, llen;
	logic [RCNT_W-1:0] rcnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_len_q   <= LEN_W'(HIST_LEN_MAX);
			life_len_q  <= LEN_W'(HIST_LEN_MAX);
			reg_count_q <= RCNT_W'(REG_COUNT_MAX);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_USE_LEN:   use_len_q   <= cfg_data;
				CFG_LIFE_LEN:  life_len_q  <= cfg_data;
				CFG_REG_COUNT: reg_count_q <= cfg_data[RCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ulen = (use_len_q == '0) ? LEN_W'(1) :
			(use_len_q > LEN_W'(HIST_LEN_MAX)) ? LEN_W'(HIST_LEN_MAX) : use_len_q;
		llen = (life_len_q == '0) ? LEN_W'(1) :
			(life_len_q > LEN_W'(HIST_LEN_MAX)) ? LEN_W'(HIST_LEN_MAX) : life_len_q;
		rcnt = (reg_count_q == '0) ? RCNT_W'(1) :
			(reg_count_q > RCNT_W'(REG_COUNT_MAX)) ? RCNT_W'(REG_COUNT_MAX) : reg_count_q;
	end

	// item registers
	logic [1:0]         func_q;
	logic [STAMP_W-1:0] stamp_q;
	logic               se_q;
	logic [REG_W-1:0]   reg_q;
	logic [2:0]         tsel_q;
	logic [BIN_W-1:0]   bin_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q  <= func;
			stamp_q <= instr_num;
			se_q    <= stats_enable;
			reg_q   <= reg_index;
			tsel_q  <= table_select;
			bin_q   <= bin_index;
		end
	end

	// clear sweep
	logic [BIN_W-1:0] clr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr) clr_q <= clr_q + BIN_W'(1);
	end
	assign stat.clr_last = (clr_q == BIN_W'(HIST_LEN_MAX - 1));

	// memories
	logic [STAMP_W-1:0] lrs_mem [REG_COUNT_MAX];
	logic [STAMP_W-1:0] lws_mem [REG_COUNT_MAX];
	logic [CNT_W-1:0]   rds_mem [REG_COUNT_MAX];
	logic [CNT_W-1:0]   wrs_mem [REG_COUNT_MAX];
	logic [CNT_W-1:0]   ri_mem  [HIST_LEN_MAX];
	logic [CNT_W-1:0]   lt_mem  [HIST_LEN_MAX];
	logic [CNT_W-1:0]   du_mem  [HIST_LEN_MAX];

	logic [STAMP_W-1:0] lrs_rd_q, lws_rd_q;
	logic [CNT_W-1:0]   rds_rd_q, wrs_rd_q, ri_rd_q, lt_rd_q, du_rd_q;
	logic [BIN_W-1:0]   ri_bin_q, du_bin_q, lt_bin_q;
	logic [1:0]         st_q;

	logic               is_ro;
	logic [REG_W-1:0]   pr_addr;
	logic [BIN_W-1:0]   ri_addr, lt_addr, du_addr;

	assign is_ro   = (func_q == FN_READOUT);
	assign pr_addr = is_ro ? bin_q[REG_W-1:0] : reg_q;
	assign ri_addr = is_ro ? bin_q : ri_bin_q;
	assign lt_addr = is_ro ? bin_q : lt_bin_q;
	assign du_addr = is_ro ? bin_q : du_bin_q;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			lrs_rd_q <= lrs_mem[pr_addr];
			lws_rd_q <= lws_mem[pr_addr];
			rds_rd_q <= rds_mem[pr_addr];
			wrs_rd_q <= wrs_mem[pr_addr];
		end
		if (cmd.hrd) begin
			ri_rd_q <= ri_mem[ri_addr];
			lt_rd_q <= lt_mem[lt_addr];
			du_rd_q <= du_mem[du_addr];
		end
	end

	// status and bins
	logic [1:0]       st_d;
	logic [LEN_W-1:0] bin_ext;
	logic             skip;

	assign bin_ext = {1'b0, bin_q};
	assign skip    = (reg_q == SKIP_REG_A) || (reg_q == SKIP_REG_B);

	always_comb begin
		st_d = ST_OK;
		if (is_ro) begin
			case (tsel_q) inside
				TBL_RI, TBL_DU:        if (bin_ext >= ulen) st_d = ST_BADBIN;
				TBL_LIFE:              if (bin_ext >= llen) st_d = ST_BADBIN;
				TBL_READS, TBL_WRITES: if (bin_ext >= LEN_W'(rcnt)) st_d = ST_BADREG;
				default:               st_d = ST_BADBIN;
			endcase
		end else if ({1'b0, reg_q} >= rcnt) begin
			st_d = ST_BADREG;
		end else if (func_q == FN_READ) begin
			if (se_q && !skip) st_d = ST_DIST;
		end else if (func_q == FN_WRITE) begin
			st_d = ST_DIST;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			ri_bin_q <= bin_of(stamp_q, lrs_rd_q, ulen);
			du_bin_q <= bin_of(stamp_q, lws_rd_q, ulen);
			lt_bin_q <= bin_of(stamp_q, lws_rd_q, llen);
			st_q     <= st_d;
		end
	end

	// write ports
	logic upd, do_rd, do_wr;
	assign upd   = cmd.wb && !is_ro && (st_q != ST_BADREG);
	assign do_rd = upd && (func_q == FN_READ) && se_q;
	assign do_wr = upd && (func_q == FN_WRITE);

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			lrs_mem[clr_q[REG_W-1:0]] <= '0;
			lws_mem[clr_q[REG_W-1:0]] <= '0;
			rds_mem[clr_q[REG_W-1:0]] <= '0;
			wrs_mem[clr_q[REG_W-1:0]] <= '0;
			ri_mem[clr_q] <= '0;
			lt_mem[clr_q] <= '0;
			du_mem[clr_q] <= '0;
		end else begin
			if (upd && (func_q == FN_RD_STAMP)) lrs_mem[reg_q] <= stamp_q;
			if (do_wr) lws_mem[reg_q] <= stamp_q;
			if (do_rd) begin
				rds_mem[reg_q]  <= rds_rd_q + CNT_W'(1);
				ri_mem[ri_addr] <= ri_rd_q + CNT_W'(1);
			end
			if (do_rd && !skip) du_mem[du_addr] <= du_rd_q + CNT_W'(1);
			if (do_wr && se_q) begin
				wrs_mem[reg_q]  <= wrs_rd_q + CNT_W'(1);
				lt_mem[lt_addr] <= lt_rd_q + CNT_W'(1);
			end
		end
	end

	// result
	logic [CNT_W-1:0] cnt_sel;
	always_comb begin
		case (tsel_q)
			TBL_RI:     cnt_sel = ri_rd_q;
			TBL_LIFE:   cnt_sel = lt_rd_q;
			TBL_DU:     cnt_sel = du_rd_q;
			TBL_READS:  cnt_sel = rds_rd_q;
			TBL_WRITES: cnt_sel = wrs_rd_q;
			default:    cnt_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= cmd.wb;
	end

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			status   <= st_q;
			distance <= (st_q != ST_DIST) ? '0 :
				(func_q == FN_READ) ? du_bin_q : lt_bin_q;
			count    <= (is_ro && st_q == ST_OK) ? cnt_sel : '0;
		end
	end

endmodule

>>> design/register_usage_histogram_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_usage_histogram_core
// Per-register read/write tracking with read interval, lifetime and def-use
// histograms and a counter readout.
//
//  channel  | handshake        | payload
//  ---------+------------------+--------------------------------------------
//  item in  | start, busy      | func instr_num stats_enable reg_index
//           |                  | table_select bin_index
//  result   | done (strobe)    | status distance count
//  config   | cfg_we           | cfg_index cfg_data
//
// The result strobe follows the last memory write-back of an item. Each item
// runs through table read, distance compute, histogram read and write-back in
// order, and the next item is accepted only after the write-back.
// After reset the block clears all tables with busy high.
// The result is shown for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module register_usage_histogram_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  func,
	input  logic [ruh_pkg::STAMP_W-1:0] instr_num,
	input  logic                        stats_enable,
	input  logic [ruh_pkg::REG_W-1:0]   reg_index,
	input  logic [2:0]                  table_select,
	input  logic [ruh_pkg::BIN_W-1:0]   bin_index,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [ruh_pkg::LEN_W-1:0]   cfg_data,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [ruh_pkg::BIN_W-1:0]   distance,
	output logic [ruh_pkg::CNT_W-1:0]   count
);
	import ruh_pkg::*;

	ruh_cmd_t  cmd;
	ruh_stat_t stat;

	ruh_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	ruh_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.func        (func),
		.instr_num   (instr_num),
		.stats_enable(stats_enable),
		.reg_index   (reg_index),
		.table_select(table_select),
		.bin_index   (bin_index),
		.done        (done),
		.status      (status),
		.distance    (distance),
		.count       (count)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without work");

	a_dist_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_DIST) |-> (distance == '0))
		else $error("distance set without distance status");

	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (count == '0))
		else $error("count set on failed item");

endmodule
